/* rtl/core/assert_macros.svh */
// Assertion helpers used by the monitor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define MFM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("mains frequency monitor check failed");

// Check a property on every clock edge, reset included.
`define MFM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
   else $error("mains frequency monitor check failed");

`endif

/* rtl/core/mfm_pkg.sv */
package mfm_pkg;

   // Default sizes.
   localparam int RING_DEPTH_DEF = 128;
   localparam int TIME_BITS_DEF  = 32;

   // Item kinds; the spare code behaves as a status poll.
   localparam logic [1:0] OP_EDGE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_POLL  = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_STALE    = 2'd1;
   localparam logic [1:0] ST_SAMPLING = 2'd2;
   localparam logic [1:0] ST_ABNORMAL = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_EXPECTED_FREQ  = 3'd0;
   localparam logic [2:0] REG_FREQ_TOLERANCE = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE_MS    = 3'd2;
   localparam logic [2:0] REG_WINDOW_MS      = 3'd3;
   localparam logic [2:0] REG_EXPECTED_EDGES = 3'd4;

   // Register reset values.
   localparam logic [7:0]  EXPECTED_FREQ_RST  = 8'd60;
   localparam logic [3:0]  FREQ_TOLERANCE_RST = 4'd3;
   localparam logic [7:0]  DEBOUNCE_MS_RST    = 8'd8;
   localparam logic [15:0] WINDOW_MS_RST      = 16'd1000;
   localparam logic [7:0]  EXPECTED_EDGES_RST = 8'd60;

   // Arithmetic constants of the average.
   localparam int RATE_NUM     = 1000;
   localparam int RATE_BITS    = 10;
   localparam int ROUND_SCALE  = 10;
   localparam int ROUND_OFFSET = 5;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/core/mfm_div.sv */
// Restoring divider, one quotient bit per cycle.
module mfm_div #(
   parameter int DW = 32,
   parameter int SB = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SB-1:0]        steps,
   input  logic [DW-1:0]        dividend,
   input  logic [DW-1:0]        divisor,
   output logic [DW-1:0]        quotient,
   output mfm_pkg::div_stat_type stat
);

   logic          run_ff;
   logic [SB-1:0] cnt_ff;
   logic [DW-1:0] dd_ff;
   logic [DW-1:0] dv_ff;
   logic [DW:0]   rem_ff;
   logic [DW-1:0] quo_ff;
   logic [DW:0]   trial;
   logic          ge;
   logic          done;

   assign done  = run_ff && (cnt_ff == '0);
   assign trial = {rem_ff[DW-1:0], dd_ff[DW-1]};
   assign ge    = trial >= {1'b0, dv_ff};

   // Control: run flag and remaining step count.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= steps;
      end else begin
         if (done) run_ff <= 1'b0;
         if (cnt_ff != '0) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Datapath: shift the dividend in one bit per step.
   always_ff @(posedge clock) begin
      if (start) begin
         dd_ff  <= dividend;
         dv_ff  <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         dd_ff  <= {dd_ff[DW-2:0], 1'b0};
         rem_ff <= ge ? (trial - {1'b0, dv_ff}) : trial;
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = run_ff;
   assign stat.done = done;

endmodule

/* rtl/core/mains_frequency_monitor_top.sv */
// Edge and poll items pass from S_IDLE through S_EXEC and S_EMIT into the registered result.
// Measuring ticks walk the n stored edges through S_RD and S_RDW and the shared bit-serial
// divider (one 1000/interval per nonzero interval, then two averaging divides) before the
// result is valid.
// A new item is taken only when the previous one has left the sequencer; a held result stalls it.
// Synchronous active-high reset clears all control state; ring contents need none.
`include "assert_macros.svh"

module mains_frequency_monitor_top #(
   parameter int RING_DEPTH = mfm_pkg::RING_DEPTH_DEF,
   parameter int TIME_BITS  = mfm_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   input  logic [1:0]  req_tuser,   // [1:0] op
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [9:2] frequency_hz, [10] edge_debounced, [11] oldest_dropped,
   // [12] no_pulse, [13] sampling_miss, [14] measured, [22:15] missing_count, [23] zero
   output logic [23:0] rsp_tdata,
   // Register writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int CX = (CW > 8) ? CW : 8;
   localparam int SW = AW + 8;
   localparam int DW = (TIME_BITS > SW + 5) ? TIME_BITS : SW + 5;
   localparam int SB = $clog2(DW + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_RDW  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_AVG1 = 3'd5;
   localparam logic [2:0] S_AVG2 = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   // Configuration registers.
   logic [7:0]  exp_freq_ff;
   logic [3:0]  tol_ff;
   logic [7:0]  debounce_ff;
   logic [15:0] window_ff;
   logic [7:0]  exp_edges_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_freq_ff  <= mfm_pkg::EXPECTED_FREQ_RST;
         tol_ff       <= mfm_pkg::FREQ_TOLERANCE_RST;
         debounce_ff  <= mfm_pkg::DEBOUNCE_MS_RST;
         window_ff    <= mfm_pkg::WINDOW_MS_RST;
         exp_edges_ff <= mfm_pkg::EXPECTED_EDGES_RST;
      end else if (csr_we) begin
         case (csr_index)
            mfm_pkg::REG_EXPECTED_FREQ:  exp_freq_ff  <= csr_wdata[7:0];
            mfm_pkg::REG_FREQ_TOLERANCE: tol_ff       <= csr_wdata[3:0];
            mfm_pkg::REG_DEBOUNCE_MS:    debounce_ff  <= csr_wdata[7:0];
            mfm_pkg::REG_WINDOW_MS:      window_ff    <= csr_wdata;
            mfm_pkg::REG_EXPECTED_EDGES: exp_edges_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Monitor state.
   logic [2:0]           state_ff, state_in;
   logic [1:0]           op_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] last_edge_ff, last_edge_in;
   logic [TIME_BITS-1:0] last_upd_ff, last_upd_in;
   logic [7:0]           freq_ff, freq_in;
   logic [7:0]           missing_ff, missing_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   // Drain walk.
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [TIME_BITS-1:0] older_ff, older_in;
   // Result flags.
   logic deb_ff, deb_in, drop_ff, drop_in, nop_ff, nop_in;
   logic miss_ff, miss_in, meas_ff, meas_in;
   logic [7:0] mout_ff, mout_in;
   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   // Ring memory.
   logic [TIME_BITS-1:0] ring_mem [RING_DEPTH];
   logic [TIME_BITS-1:0] rdata_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;

   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_addr] <= now_ff;
      rdata_ff <= ring_mem[ptr_ff];
   end

   // Shared divider.
   logic                  div_start;
   logic [SB-1:0]         div_steps;
   logic [DW-1:0]         div_dividend, div_divisor, div_quo;
   mfm_pkg::div_stat_type div_stat;

   mfm_div #(.DW(DW), .SB(SB)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // Combinational helpers.
   logic [TIME_BITS-1:0] since_edge, since_upd, diff;
   logic                 stale;
   logic [CW:0]          tail_sum;
   logic [AW-1:0]        tail_addr, ptr_next, head_next;
   logic [7:0]           m_val;
   logic [CX-1:0]        count_x;
   logic                 last_elem;
   logic [SW+3:0]        sum_x10;
   logic [CW-1:0]        n_minus1;
   logic [8:0]           f_lo, f_hi;
   logic [1:0]           status;
   logic                 out_free;

   assign since_edge = now_ff - last_edge_ff;
   assign since_upd  = now_ff - last_upd_ff;
   assign diff       = rdata_ff - older_ff;
   assign stale      = {{(33 - TIME_BITS){1'b0}}, since_upd} >= {16'b0, window_ff, 1'b0};
   assign tail_sum   = {1'b0, CW'(head_ff)} + {1'b0, count_ff};
   assign tail_addr  = (tail_sum >= (CW + 1)'(RING_DEPTH))
                       ? AW'(tail_sum - (CW + 1)'(RING_DEPTH)) : AW'(tail_sum);
   assign ptr_next   = (ptr_ff == AW'(RING_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign head_next  = (head_ff == AW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign count_x    = CX'(count_ff);
   assign m_val      = exp_edges_ff - count_x[7:0];
   assign last_elem  = (idx_ff == count_ff - 1'b1);
   assign sum_x10    = {sum_ff, 3'b000} + {2'b00, sum_ff, 1'b0};
   assign n_minus1   = count_ff - 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Status after the item.
   assign f_lo = {1'b0, freq_ff} + {5'b0, tol_ff};
   assign f_hi = {1'b0, exp_freq_ff} + {5'b0, tol_ff};
   always_comb begin
      if (stale) begin
         status = mfm_pkg::ST_STALE;
      end else if ($signed(missing_ff) > $signed({4'b0000, tol_ff})) begin
         status = mfm_pkg::ST_SAMPLING;
      end else if ((f_lo < {1'b0, exp_freq_ff}) || ({1'b0, freq_ff} > f_hi)) begin
         status = mfm_pkg::ST_ABNORMAL;
      end else begin
         status = mfm_pkg::ST_OK;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      last_edge_in = last_edge_ff;
      last_upd_in  = last_upd_ff;
      freq_in      = freq_ff;
      missing_in   = missing_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      older_in     = older_ff;
      deb_in       = deb_ff;
      drop_in      = drop_ff;
      nop_in       = nop_ff;
      miss_in      = miss_ff;
      meas_in      = meas_ff;
      mout_in      = mout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_addr;
      div_start    = 1'b0;
      div_steps    = SB'(mfm_pkg::RATE_BITS);
      div_dividend = DW'(mfm_pkg::RATE_NUM) << (DW - mfm_pkg::RATE_BITS);
      div_divisor  = DW'(diff);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            deb_in   = 1'b0;
            drop_in  = 1'b0;
            nop_in   = 1'b0;
            miss_in  = 1'b0;
            meas_in  = 1'b0;
            mout_in  = missing_ff;
            state_in = S_EMIT;
            if (op_ff == mfm_pkg::OP_EDGE) begin
               if (since_edge < TIME_BITS'(debounce_ff)) begin
                  deb_in = 1'b1;
               end else begin
                  last_edge_in = now_ff;
                  wr_en        = 1'b1;
                  if (count_ff >= CW'(RING_DEPTH)) begin
                     drop_in = 1'b1;
                     wr_addr = head_ff;
                     head_in = head_next;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end else if (op_ff == mfm_pkg::OP_TICK) begin
               if (stale) freq_in = '0;
               if (since_edge >= TIME_BITS'(window_ff)) begin
                  nop_in = 1'b1;
               end else begin
                  mout_in    = m_val;
                  missing_in = m_val;
                  if ($signed(m_val) > $signed({4'b0000, tol_ff})) begin
                     miss_in = 1'b1;
                  end else begin
                     meas_in     = 1'b1;
                     last_upd_in = now_ff;
                     missing_in  = '0;
                     ptr_in      = head_ff;
                     idx_in      = '0;
                     sum_in      = '0;
                     if (count_ff == '0) begin
                        freq_in = '0;
                     end else begin
                        state_in = S_RD;
                     end
                  end
               end
            end
         end
         S_RD: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            older_in = rdata_ff;
            if ((idx_ff != '0) && (diff != '0)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (last_elem) begin
               head_in  = ptr_next;
               count_in = '0;
               if (idx_ff == '0) begin
                  // A single stored edge gives no interval.
                  freq_in  = '0;
                  state_in = S_EMIT;
               end else begin
                  // The last interval was zero and adds nothing to the sum.
                  div_start    = 1'b1;
                  div_steps    = SB'(DW);
                  div_dividend = DW'(sum_x10);
                  div_divisor  = DW'(n_minus1);
                  state_in     = S_AVG1;
               end
            end else begin
               ptr_in   = ptr_next;
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               sum_in = sum_ff + SW'(div_quo[7:0]);
               if (last_elem) begin
                  head_in      = ptr_next;
                  count_in     = '0;
                  div_start    = 1'b1;
                  div_steps    = SB'(DW);
                  div_dividend = DW'(sum_x10 + {4'b0000, div_quo[7:0]} * 4'd10);
                  div_divisor  = DW'(n_minus1);
                  state_in     = S_AVG1;
               end else begin
                  ptr_in   = ptr_next;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_AVG1: begin
            if (div_stat.done) begin
               div_start    = 1'b1;
               div_steps    = SB'(DW);
               div_dividend = div_quo + DW'(mfm_pkg::ROUND_OFFSET);
               div_divisor  = DW'(mfm_pkg::ROUND_SCALE);
               state_in     = S_AVG2;
            end
         end
         S_AVG2: begin
            if (div_stat.done) begin
               freq_in  = div_quo[7:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, mout_ff, meas_ff, miss_ff, nop_ff, drop_ff, deb_ff,
                               freq_ff, status};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_edge_ff <= '0;
         last_upd_ff  <= '0;
         freq_ff      <= '0;
         missing_ff   <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_edge_ff <= last_edge_in;
         last_upd_ff  <= last_upd_in;
         freq_ff      <= freq_in;
         missing_ff   <= missing_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff  <= req_tuser;
         now_ff <= req_tdata[TIME_BITS-1:0];
      end
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      older_ff    <= older_in;
      deb_ff      <= deb_in;
      drop_ff     <= drop_in;
      nop_ff      <= nop_in;
      miss_ff     <= miss_in;
      meas_ff     <= meas_in;
      mout_ff     <= mout_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks.
   `MFM_ASSERT(a_count_range, count_ff <= CW'(RING_DEPTH))
   `MFM_ASSERT(a_meas_drained, (state_ff == S_EMIT && out_free && meas_ff) |=> (count_ff == '0))
   `MFM_ASSERT(a_div_start_free, div_start |-> (!div_stat.busy || div_stat.done))
   `MFM_ASSERT(a_idle_div_quiet, (state_ff == S_IDLE) |-> !div_stat.busy)

endmodule
